### design/aarm_pkg.sv
// shared types, constants and tables for the axis-angle rotation matrix block
package aarm_pkg;

  // field formats
  localparam int IN_WIDTH    = 16;
  localparam int ENTRY_WIDTH = 16;
  localparam int IN_FRAC     = 12;
  localparam int ENTRY_FRAC  = ENTRY_WIDTH - 2;
  localparam int QF          = 30;

  // axis normalization
  localparam int N2_W       = 64;
  localparam int ROOT_W     = 32;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int SHIFT_W    = 5;
  localparam int UNIT_W     = 32;
  localparam int QUO_W      = QF + 1;

  // angle path
  localparam int ANG_W        = IN_WIDTH + QF - IN_FRAC;
  localparam int RED_STEPS    = (IN_WIDTH > 15) ? IN_WIDTH - 15 : 1;
  localparam int Z_W          = 35;
  localparam int TRIG_W       = 34;
  localparam int CORDIC_STEPS = 30;

  // stage counts of the two parallel paths and of the product stage
  localparam int SQRT_LAT = ROOT_STEPS + 2;
  localparam int DIV_LAT  = QUO_W + 1;
  localparam int AXIS_LAT = SQRT_LAT + DIV_LAT;
  localparam int TRIG_DLY = AXIS_LAT - RED_STEPS - CORDIC_STEPS - 3;
  localparam int ROD_LAT  = 3;

  // Q.30 constants
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] CORDIC_GAIN = 64'd652032874;

  localparam logic signed [ENTRY_WIDTH-1:0] ENTRY_ONE = ENTRY_WIDTH'(1 << ENTRY_FRAC);

  // arctangent of 2^-idx in Q.30
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000007;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic signed [IN_WIDTH-1:0] angle;
    logic signed [IN_WIDTH-1:0] axis_x;
    logic signed [IN_WIDTH-1:0] axis_y;
    logic signed [IN_WIDTH-1:0] axis_z;
  } in_t;

  typedef struct packed {
    logic signed [ENTRY_WIDTH-1:0] m00;
    logic signed [ENTRY_WIDTH-1:0] m01;
    logic signed [ENTRY_WIDTH-1:0] m02;
    logic signed [ENTRY_WIDTH-1:0] m10;
    logic signed [ENTRY_WIDTH-1:0] m11;
    logic signed [ENTRY_WIDTH-1:0] m12;
    logic signed [ENTRY_WIDTH-1:0] m20;
    logic signed [ENTRY_WIDTH-1:0] m21;
    logic signed [ENTRY_WIDTH-1:0] m22;
    logic                          axis_zero;
  } out_t;

  // axis magnitudes and squared length
  typedef struct packed {
    logic [2:0]               neg;
    logic [2:0][IN_WIDTH-1:0] mag;
    logic [N2_W-1:0]          n2;
    logic                     zero;
  } axis_sq_t;

  // scaled magnitudes and root of the scaled squared length
  typedef struct packed {
    logic [2:0]             neg;
    logic [2:0][ROOT_W-1:0] num;
    logic [ROOT_W-1:0]      root;
    logic                   zero;
  } axis_root_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] ux;
    logic signed [UNIT_W-1:0] uy;
    logic signed [UNIT_W-1:0] uz;
    logic                     zero;
  } unit_t;

  typedef struct packed {
    logic             neg;
    logic [ANG_W-1:0] mag;
  } angle_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cs;
    logic signed [TRIG_W-1:0] sn;
  } trig_t;

endpackage

### design/aarm_prep.sv
// input stage: magnitudes, squared axis length and angle in Q.30
module aarm_prep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  aarm_pkg::in_t     data_i,
  output logic              valid_o,
  output aarm_pkg::axis_sq_t axis_o,
  output aarm_pkg::angle_t  ang_o
);

  localparam int IW   = aarm_pkg::IN_WIDTH;
  localparam int SQ_W = 2 * IW;
  localparam int ASH  = aarm_pkg::QF - aarm_pkg::IN_FRAC;

  logic signed [IW-1:0] comp [3];
  logic [2:0]           neg;
  logic [2:0][IW-1:0]   mag;
  logic [SQ_W-1:0]      sq [3];
  logic [IW-1:0]        ang_mag;
  aarm_pkg::axis_sq_t   axis_d, axis_q;
  aarm_pkg::angle_t     ang_d, ang_q;
  logic                 valid_q;

  // magnitudes and squares
  always_comb begin
    comp[0] = data_i.axis_x;
    comp[1] = data_i.axis_y;
    comp[2] = data_i.axis_z;
    for (int i = 0; i < 3; i++) begin
      neg[i] = comp[i][IW-1];
      mag[i] = neg[i] ? IW'(-comp[i]) : IW'(comp[i]);
      sq[i]  = SQ_W'(mag[i]) * SQ_W'(mag[i]);
    end
    axis_d.neg  = neg;
    axis_d.mag  = mag;
    axis_d.n2   = aarm_pkg::N2_W'(sq[0]) + aarm_pkg::N2_W'(sq[1]) + aarm_pkg::N2_W'(sq[2]);
    axis_d.zero = (mag == '0);
    ang_mag     = data_i.angle[IW-1] ? IW'(-data_i.angle) : IW'(data_i.angle);
    ang_d.neg   = data_i.angle[IW-1];
    ang_d.mag   = {ang_mag, {ASH{1'b0}}};
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      axis_q <= axis_d;
      ang_q  <= ang_d;
    end
  end

  assign valid_o = valid_q;
  assign axis_o  = axis_q;
  assign ang_o   = ang_q;

endmodule

### design/aarm_sqrt.sv
// normalizing shift and pipelined integer square root of the axis length
module aarm_sqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  aarm_pkg::axis_sq_t   axis_i,
  output logic                 valid_o,
  output aarm_pkg::axis_root_t axis_o
);

  localparam int N2_W   = aarm_pkg::N2_W;
  localparam int ROOT_W = aarm_pkg::ROOT_W;
  localparam int STEPS  = aarm_pkg::ROOT_STEPS;
  localparam int LAT    = aarm_pkg::SQRT_LAT;
  localparam int REM_W  = ROOT_W + 2;
  localparam int PAIRS  = N2_W / 2;

  typedef struct packed {
    logic [N2_W-1:0]        n;
    logic [REM_W-1:0]       rem;
    logic [ROOT_W-1:0]      root;
    logic [2:0][ROOT_W-1:0] num;
    logic [2:0]             neg;
    logic                   zero;
  } root_stage_t;

  logic [LAT-1:0]                  vld_q;
  logic [aarm_pkg::SHIFT_W-1:0]    e_d, lz_e_q;
  aarm_pkg::axis_sq_t              lz_axis_q;
  root_stage_t                     sh_d;
  root_stage_t                     st_q [STEPS+1];

  // half the leading zero count, in bit pairs
  always_comb begin
    e_d = '0;
    for (int j = 0; j < PAIRS; j++) begin
      if (axis_i.n2[2*j +: 2] != 2'b00) begin
        e_d = aarm_pkg::SHIFT_W'(PAIRS - 1 - j);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lz_e_q    <= e_d;
      lz_axis_q <= axis_i;
    end
  end

  // scale length and magnitudes
  always_comb begin
    sh_d.n    = lz_axis_q.n2 << {lz_e_q, 1'b0};
    sh_d.rem  = '0;
    sh_d.root = '0;
    for (int i = 0; i < 3; i++) begin
      sh_d.num[i] = ROOT_W'(N2_W'(lz_axis_q.mag[i]) << lz_e_q);
    end
    sh_d.neg  = lz_axis_q.neg;
    sh_d.zero = lz_axis_q.zero;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= sh_d;
    end
  end

  // one root bit per stage
  for (genvar g = 0; g < STEPS; g++) begin : g_root
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    root_stage_t      nxt;

    always_comb begin
      cur   = {st_q[g].rem, st_q[g].n[N2_W-1 -: 2]};
      trial = (REM_W + 2)'({st_q[g].root, 2'b01});
      nxt   = st_q[g];
      nxt.n = st_q[g].n << 2;
      if (cur >= trial) begin
        nxt.rem  = REM_W'(cur - trial);
        nxt.root = {st_q[g].root[ROOT_W-2:0], 1'b1};
      end else begin
        nxt.rem  = REM_W'(cur);
        nxt.root = {st_q[g].root[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g+1] <= nxt;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LAT-2:0], valid_i};
    end
  end

  assign valid_o     = vld_q[LAT-1];
  assign axis_o.neg  = st_q[STEPS].neg;
  assign axis_o.num  = st_q[STEPS].num;
  assign axis_o.root = st_q[STEPS].root;
  assign axis_o.zero = st_q[STEPS].zero;

endmodule

### design/aarm_div.sv
// pipelined restoring divide of the three axis components by the root
module aarm_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  aarm_pkg::axis_root_t axis_i,
  output logic                 valid_o,
  output aarm_pkg::unit_t      unit_o
);

  localparam int ROOT_W = aarm_pkg::ROOT_W;
  localparam int QUO_W  = aarm_pkg::QUO_W;
  localparam int UNIT_W = aarm_pkg::UNIT_W;
  localparam int LAT    = aarm_pkg::DIV_LAT;

  typedef struct packed {
    logic [2:0][ROOT_W-1:0] rem;
    logic [2:0][QUO_W-1:0]  quo;
    logic [ROOT_W-1:0]      root;
    logic [2:0]             neg;
    logic                   zero;
  } div_stage_t;

  logic [LAT-1:0]   vld_q;
  div_stage_t       init;
  div_stage_t       st_q [QUO_W];
  aarm_pkg::unit_t  unit_d, unit_q;
  logic [UNIT_W-1:0] qmag [3];
  logic signed [UNIT_W-1:0] comp [3];

  always_comb begin
    init.rem  = axis_i.num;
    init.quo  = '0;
    init.root = axis_i.root;
    init.neg  = axis_i.neg;
    init.zero = axis_i.zero;
  end

  // one quotient bit per stage; the first has no shift
  for (genvar g = 0; g < QUO_W; g++) begin : g_quo
    div_stage_t        src;
    div_stage_t        nxt;
    logic [ROOT_W:0]   t [3];
    logic              b [3];

    if (g == 0) begin : g_first
      assign src = init;
    end else begin : g_next
      assign src = st_q[g-1];
    end

    always_comb begin
      nxt = src;
      for (int i = 0; i < 3; i++) begin
        t[i] = (g == 0) ? {1'b0, src.rem[i]} : {src.rem[i], 1'b0};
        b[i] = (t[i] >= {1'b0, src.root});
        nxt.rem[i] = b[i] ? ROOT_W'(t[i] - {1'b0, src.root}) : ROOT_W'(t[i]);
        nxt.quo[i] = {src.quo[i][QUO_W-2:0], b[i]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g] <= nxt;
      end
    end
  end

  // apply component signs
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qmag[i] = UNIT_W'(st_q[QUO_W-1].quo[i]);
      comp[i] = st_q[QUO_W-1].neg[i] ? -$signed(qmag[i]) : $signed(qmag[i]);
    end
    unit_d.ux   = comp[0];
    unit_d.uy   = comp[1];
    unit_d.uz   = comp[2];
    unit_d.zero = st_q[QUO_W-1].zero;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unit_q <= unit_d;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LAT-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[LAT-1];
  assign unit_o  = unit_q;

endmodule

### design/aarm_cordic.sv
// angle reduction, pipelined cordic for sine and cosine, and alignment delay
module aarm_cordic (
  input  logic             clk_i,
  input  logic             en_i,
  input  aarm_pkg::angle_t ang_i,
  output aarm_pkg::trig_t  trig_o
);

  localparam int ANG_W  = aarm_pkg::ANG_W;
  localparam int Z_W    = aarm_pkg::Z_W;
  localparam int TRIG_W = aarm_pkg::TRIG_W;
  localparam int RED    = aarm_pkg::RED_STEPS;
  localparam int STEPS  = aarm_pkg::CORDIC_STEPS;
  localparam int DLY    = aarm_pkg::TRIG_DLY;

  localparam logic signed [Z_W-1:0] ZPI      = Z_W'(aarm_pkg::PI_Q30);
  localparam logic signed [Z_W-1:0] ZTWO_PI  = Z_W'(aarm_pkg::TWO_PI_Q30);
  localparam logic signed [Z_W-1:0] ZHALF_PI = Z_W'(aarm_pkg::HALF_PI_Q30);
  localparam logic signed [TRIG_W-1:0] GAIN  = TRIG_W'(aarm_pkg::CORDIC_GAIN);

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [Z_W-1:0]    z;
    logic                     flip;
  } cor_t;

  aarm_pkg::angle_t      red_q [RED];
  logic signed [Z_W-1:0] m, r0, r1_d, r1_q;
  cor_t                  fold_d;
  cor_t                  cor_q [STEPS+1];
  aarm_pkg::trig_t       fin_d;
  aarm_pkg::trig_t       dly_q [DLY+1];

  // magnitude modulo 2*pi, one multiple per stage
  for (genvar g = 0; g < RED; g++) begin : g_red
    localparam int K = RED - 1 - g;
    localparam logic [ANG_W-1:0] STEP_C = ANG_W'(aarm_pkg::TWO_PI_Q30 << K);
    aarm_pkg::angle_t src;
    aarm_pkg::angle_t nxt;

    if (g == 0) begin : g_first
      assign src = ang_i;
    end else begin : g_next
      assign src = red_q[g-1];
    end

    always_comb begin
      nxt = src;
      if (src.mag >= STEP_C) begin
        nxt.mag = src.mag - STEP_C;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        red_q[g] <= nxt;
      end
    end
  end

  // floor modulo, then into (-pi, pi]
  always_comb begin
    m    = Z_W'(red_q[RED-1].mag);
    r0   = (red_q[RED-1].neg && (m != '0)) ? ZTWO_PI - m : m;
    r1_d = (r0 > ZPI) ? r0 - ZTWO_PI : r0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_q <= r1_d;
    end
  end

  // fold into [-pi/2, pi/2]
  always_comb begin
    fold_d.x = GAIN;
    fold_d.y = '0;
    if (r1_q > ZHALF_PI) begin
      fold_d.z    = r1_q - ZPI;
      fold_d.flip = 1'b1;
    end else if (r1_q < -ZHALF_PI) begin
      fold_d.z    = r1_q + ZPI;
      fold_d.flip = 1'b1;
    end else begin
      fold_d.z    = r1_q;
      fold_d.flip = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cor_q[0] <= fold_d;
    end
  end

  // one rotation per stage
  for (genvar g = 0; g < STEPS; g++) begin : g_rot
    localparam logic signed [Z_W-1:0] ATAN = Z_W'(aarm_pkg::atan_q30(5'(g)));
    logic signed [TRIG_W-1:0] x, y, dx, dy;
    logic signed [Z_W-1:0]    z;
    cor_t                     nxt;

    always_comb begin
      x   = cor_q[g].x;
      y   = cor_q[g].y;
      z   = cor_q[g].z;
      dx  = y >>> g;
      dy  = x >>> g;
      nxt = cor_q[g];
      if (z >= 0) begin
        nxt.x = x - dx;
        nxt.y = y + dy;
        nxt.z = z - ATAN;
      end else begin
        nxt.x = x + dx;
        nxt.y = y - dy;
        nxt.z = z + ATAN;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cor_q[g+1] <= nxt;
      end
    end
  end

  // undo the fold
  always_comb begin
    fin_d.cs = cor_q[STEPS].flip ? -cor_q[STEPS].x : cor_q[STEPS].x;
    fin_d.sn = cor_q[STEPS].flip ? -cor_q[STEPS].y : cor_q[STEPS].y;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dly_q[0] <= fin_d;
    end
  end

  // line up with the axis path
  for (genvar j = 1; j <= DLY; j++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dly_q[j] <= dly_q[j-1];
      end
    end
  end

  assign trig_o = dly_q[DLY];

endmodule

### design/aarm_rod.sv
// rodrigues products, sums, rounding and saturation of the nine entries
module aarm_rod (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  aarm_pkg::unit_t unit_i,
  input  aarm_pkg::trig_t trig_i,
  output logic            valid_o,
  output aarm_pkg::out_t  data_o
);

  localparam int UNIT_W = aarm_pkg::UNIT_W;
  localparam int TRIG_W = aarm_pkg::TRIG_W;
  localparam int QF     = aarm_pkg::QF;
  localparam int EW     = aarm_pkg::ENTRY_WIDTH;
  localparam int P_W    = 34;
  localparam int OC_W   = TRIG_W + 1;
  localparam int SUM_W  = 36;
  localparam int SH     = QF - aarm_pkg::ENTRY_FRAC;
  localparam int LAT    = aarm_pkg::ROD_LAT;

  localparam logic signed [OC_W-1:0]  ONE_Q = OC_W'(64'd1 << QF);
  localparam logic signed [SUM_W-1:0] RND   = SUM_W'(64'd1 << (SH - 1));
  localparam logic signed [SUM_W-1:0] HI    = SUM_W'((64'd1 << (EW - 1)) - 64'd1);
  localparam logic signed [SUM_W-1:0] LO    = -HI - SUM_W'(1);

  function automatic logic signed [EW-1:0] to_entry(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = (v + RND) >>> SH;
    if (r > HI) begin
      r = HI;
    end else if (r < LO) begin
      r = LO;
    end
    return EW'(r);
  endfunction

  logic [LAT-1:0]                  vld_q;
  logic signed [UNIT_W-1:0]        u [3];
  logic signed [TRIG_W-1:0]        sn;
  logic signed [2*UNIT_W-1:0]      pu [6];
  logic signed [UNIT_W+TRIG_W-1:0] ps [3];
  logic signed [P_W-1:0]           uu_d [6], uu_q [6];
  logic signed [P_W-1:0]           us_d [3], us_q [3];
  logic signed [TRIG_W-1:0]        cs_q, cs2_q;
  logic signed [OC_W-1:0]          oc_d, oc_q;
  logic                            zero_q, zero2_q;
  logic signed [P_W+OC_W-1:0]      po [6];
  logic signed [P_W-1:0]           q_d [6], q_q [6];
  logic signed [P_W-1:0]           s2_q [3];
  logic signed [SUM_W-1:0]         cs_e;
  logic signed [SUM_W-1:0]         qe [6];
  logic signed [SUM_W-1:0]         se [3];
  logic signed [SUM_W-1:0]         msum [9];
  logic signed [EW-1:0]            ent [9];
  aarm_pkg::out_t                  out_d, out_q;

  // first products: unit pairs and unit times sine
  always_comb begin
    u[0]  = unit_i.ux;
    u[1]  = unit_i.uy;
    u[2]  = unit_i.uz;
    sn    = trig_i.sn;
    pu[0] = u[0] * u[0];
    pu[1] = u[1] * u[1];
    pu[2] = u[2] * u[2];
    pu[3] = u[0] * u[1];
    pu[4] = u[0] * u[2];
    pu[5] = u[1] * u[2];
    for (int k = 0; k < 6; k++) begin
      uu_d[k] = P_W'(pu[k] >>> QF);
    end
    for (int k = 0; k < 3; k++) begin
      ps[k]   = u[k] * sn;
      us_d[k] = P_W'(ps[k] >>> QF);
    end
    oc_d = ONE_Q - OC_W'(trig_i.cs);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      uu_q   <= uu_d;
      us_q   <= us_d;
      cs_q   <= trig_i.cs;
      oc_q   <= oc_d;
      zero_q <= unit_i.zero;
    end
  end

  // second products: times one minus cosine
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      po[k]  = uu_q[k] * oc_q;
      q_d[k] = P_W'(po[k] >>> QF);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q     <= q_d;
      s2_q    <= us_q;
      cs2_q   <= cs_q;
      zero2_q <= zero_q;
    end
  end

  // entry sums, rounding and saturation
  always_comb begin
    cs_e = SUM_W'(cs2_q);
    for (int k = 0; k < 6; k++) begin
      qe[k] = SUM_W'(q_q[k]);
    end
    for (int k = 0; k < 3; k++) begin
      se[k] = SUM_W'(s2_q[k]);
    end
    msum[0] = cs_e + qe[0];
    msum[1] = qe[3] - se[2];
    msum[2] = qe[4] + se[1];
    msum[3] = qe[3] + se[2];
    msum[4] = cs_e + qe[1];
    msum[5] = qe[5] - se[0];
    msum[6] = qe[4] - se[1];
    msum[7] = qe[5] + se[0];
    msum[8] = cs_e + qe[2];
    for (int k = 0; k < 9; k++) begin
      if (zero2_q) begin
        ent[k] = (k % 4 == 0) ? aarm_pkg::ENTRY_ONE : '0;
      end else begin
        ent[k] = to_entry(msum[k]);
      end
    end
    out_d.m00       = ent[0];
    out_d.m01       = ent[1];
    out_d.m02       = ent[2];
    out_d.m10       = ent[3];
    out_d.m11       = ent[4];
    out_d.m12       = ent[5];
    out_d.m20       = ent[6];
    out_d.m21       = ent[7];
    out_d.m22       = ent[8];
    out_d.axis_zero = zero2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LAT-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[LAT-1];
  assign data_o  = out_q;

endmodule

### design/axis_angle_rotation_matrix.sv
// top level: axis-angle to 3x3 rotation matrix, fully pipelined
// an input passes through prep, square root and divide, with cordic alongside, then the products
// throughput: one item per cycle while the output is not stalled; the 32-step root and 31-step divide set the depth
// a stall at the output holds every stage in place; ready is low only while stalled
// reset clears the stage valid bits only; data registers are not reset
module axis_angle_rotation_matrix (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  aarm_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output aarm_pkg::out_t out_data_o
);

  logic                 en;
  logic                 prep_valid, sqrt_valid, div_valid;
  aarm_pkg::axis_sq_t   axis_sq;
  aarm_pkg::angle_t     ang;
  aarm_pkg::axis_root_t axis_root;
  aarm_pkg::unit_t      unit;
  aarm_pkg::trig_t      trig;

  // whole pipeline advances unless a result waits
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  aarm_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (prep_valid),
    .axis_o  (axis_sq),
    .ang_o   (ang)
  );

  aarm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prep_valid),
    .axis_i  (axis_sq),
    .valid_o (sqrt_valid),
    .axis_o  (axis_root)
  );

  aarm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqrt_valid),
    .axis_i  (axis_root),
    .valid_o (div_valid),
    .unit_o  (unit)
  );

  aarm_cordic u_cordic (
    .clk_i  (clk_i),
    .en_i   (en),
    .ang_i  (ang),
    .trig_o (trig)
  );

  aarm_rod u_rod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .unit_i  (unit),
    .trig_i  (trig),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  // zero axis gives the identity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.axis_zero |->
      out_data_o.m00 == aarm_pkg::ENTRY_ONE && out_data_o.m11 == aarm_pkg::ENTRY_ONE &&
      out_data_o.m22 == aarm_pkg::ENTRY_ONE && out_data_o.m01 == '0 &&
      out_data_o.m02 == '0 && out_data_o.m10 == '0 && out_data_o.m12 == '0 &&
      out_data_o.m20 == '0 && out_data_o.m21 == '0)
    else $error("zero axis result is not the identity");

  // a held result freezes the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while the result is held");

  // a held result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("held result changed");

endmodule
